// ----- rtl/tga_pkg.sv -----
package tga_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PALETTE_DEF = 256;
  localparam int DIM_BITS_DEF    = 16;

  // One byte of the incoming file stream
  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
  } byte_t;

  // One decoded result
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  comp0;
    logic [7:0]  comp1;
    logic [7:0]  comp2;
    logic [7:0]  comp3;
    logic        image_end;
  } res_t;

  // Result kinds
  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_INFO    = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_COMPRESSED = 3'd1;
  localparam logic [2:0] ERR_BAD_TYPE   = 3'd2;
  localparam logic [2:0] ERR_BAD_FORMAT = 3'd3;
  localparam logic [2:0] ERR_PAL_LARGE  = 3'd4;

  // Format codes reported in the info result
  localparam logic [7:0] FMT_INDEXED = 8'd1;
  localparam logic [7:0] FMT_RGB     = 8'd2;
  localparam logic [7:0] FMT_RGBA    = 8'd3;
  localparam logic [7:0] FMT_GRAY    = 8'd4;

  // Image type codes (low three bits) and the RLE flag
  localparam logic [2:0] TYPE_MAPPED = 3'd1;
  localparam logic [2:0] TYPE_TRUE   = 3'd2;
  localparam logic [2:0] TYPE_GRAY   = 3'd3;
  localparam int         TYPE_RLE_BIT = 3;

  // Pixel depths
  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // Image descriptor: top-origin flag
  localparam int DESC_TOP_BIT = 5;

  // Header byte offsets
  localparam logic [4:0] HDR_ID_LEN     = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
  localparam logic [4:0] HDR_CMAP_LEN_L = 5'd5;
  localparam logic [4:0] HDR_CMAP_LEN_H = 5'd6;
  localparam logic [4:0] HDR_WIDTH_L    = 5'd12;
  localparam logic [4:0] HDR_WIDTH_H    = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_L   = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_H   = 5'd15;
  localparam logic [4:0] HDR_DEPTH      = 5'd16;
  localparam logic [4:0] HDR_DESC       = 5'd17;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_ID      = 5'b00010,
    PH_PALETTE = 5'b00100,
    PH_PIXELS  = 5'b01000,
    PH_IDLE    = 5'b10000
  } phase_t;

endpackage

// ----- rtl/tga_stream_decoder.sv -----
// Streaming decoder for uncompressed TGA files.
//
// Byte channel (byte_valid, byte_stall, byte_data): one file byte per
// transfer. frame_start on a byte restarts parsing with that byte as
// header byte 0. Result channel (res_valid, res_stall, res_data): at most
// one result per input byte: an info or error result after the 18-byte
// header, one result per 3-byte palette entry, one per pixel.
//
// Throughput: one byte per cycle while byte_stall is low. The parser state
// and the result register are updated in the cycle a byte is taken, so a
// result appears on res_valid in the cycle after the byte that completes it.
// The single result register parts the two sides: a new byte is taken
// whenever the result register is empty or is being drained in the same
// cycle; byte_stall rises only while a result is held under res_stall.
//
// Reset (rst, synchronous) returns the parser to the header phase with all
// counters cleared and drops any pending result. After an error, or after
// the final pixel, further bytes are taken and dropped until frame_start.
module tga_stream_decoder #(
  parameter int MAX_PALETTE = tga_pkg::MAX_PALETTE_DEF,
  parameter int DIM_BITS    = tga_pkg::DIM_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  tga_pkg::byte_t byte_data,
  output logic          res_valid,
  input  logic          res_stall,
  output tga_pkg::res_t res_data
);

  // Palette index width: must hold MAX_PALETTE itself after the last entry
  localparam int PW = $clog2(MAX_PALETTE + 1);
  localparam logic [16:0] DIM_LIM = 17'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [16:0] PAL_LIM = 17'(MAX_PALETTE);

  // Parser state
  tga_pkg::phase_t       phase, phase_next;
  logic [4:0]            header_count, header_count_next;
  logic [7:0]            id_left, id_left_next;
  logic [7:0]            palette_kind, palette_kind_next;
  logic [7:0]            type_code, type_code_next;
  logic [15:0]           palette_count, palette_count_next;
  logic [PW-1:0]         palette_pos, palette_pos_next;
  logic [15:0]           width_reg, width_reg_next;
  logic [15:0]           height_reg, height_reg_next;
  logic [7:0]            depth_bits, depth_bits_next;
  logic                  top_origin, top_origin_next;
  logic [1:0]            byte_in_pixel, byte_in_pixel_next;
  logic [2:0][7:0]       pixel_bytes, pixel_bytes_next;
  logic [DIM_BITS-1:0]   col_count, col_count_next;
  logic [DIM_BITS-1:0]   rows_done, rows_done_next;

  logic                  res_valid_next;
  tga_pkg::res_t         res_new;
  logic                  res_fire;

  logic                  take;
  logic                  fs;
  logic [7:0]            b;
  tga_pkg::phase_t       ph;
  logic [4:0]            hc;

  logic                  empty_img;
  tga_pkg::phase_t       after_id;
  logic [2:0]            hdr_err;
  logic [7:0]            hdr_fmt;
  logic                  fmt_ok;
  logic [2:0]            tlow;
  logic [7:0]            id_dec;
  logic [PW-1:0]         pos_inc;
  logic                  is_true;
  logic                  is_32;
  logic                  pix_done;
  logic [DIM_BITS-1:0]   col_inc;
  logic [DIM_BITS-1:0]   rows_inc;

  // Take a byte unless a held result is stalled
  assign byte_stall = res_valid & res_stall;
  assign take       = byte_valid & ~byte_stall;

  assign fs = byte_data.frame_start;
  assign b  = byte_data.data_byte;
  // frame_start acts as a reset of the parser for this very byte
  assign ph = fs ? tga_pkg::PH_HEADER : phase;
  assign hc = fs ? 5'd0 : header_count;

  assign empty_img = (width_reg == 16'd0) || (height_reg == 16'd0);
  assign after_id  = (palette_count != 16'd0) ? tga_pkg::PH_PALETTE :
                     (!empty_img ? tga_pkg::PH_PIXELS : tga_pkg::PH_IDLE);

  // Header check, highest precedence first
  assign tlow = type_code[2:0];
  always_comb begin
    hdr_fmt = 8'd0;
    fmt_ok  = 1'b0;
    hdr_err = tga_pkg::ERR_NONE;
    case (tlow)
      tga_pkg::TYPE_MAPPED: begin
        fmt_ok  = (palette_kind == 8'd1) && (depth_bits == tga_pkg::DEPTH_8);
        hdr_fmt = tga_pkg::FMT_INDEXED;
      end
      tga_pkg::TYPE_TRUE: begin
        fmt_ok  = (palette_kind == 8'd0) &&
                  ((depth_bits == tga_pkg::DEPTH_24) || (depth_bits == tga_pkg::DEPTH_32));
        hdr_fmt = (depth_bits == tga_pkg::DEPTH_32) ? tga_pkg::FMT_RGBA : tga_pkg::FMT_RGB;
      end
      tga_pkg::TYPE_GRAY: begin
        fmt_ok  = (palette_kind == 8'd0) && (depth_bits == tga_pkg::DEPTH_8);
        hdr_fmt = tga_pkg::FMT_GRAY;
      end
      default: begin
        fmt_ok  = 1'b0;
        hdr_fmt = 8'd0;
      end
    endcase
    if (({1'b0, width_reg} > DIM_LIM) || ({1'b0, height_reg} > DIM_LIM)) begin
      fmt_ok = 1'b0;
    end
    if (type_code[tga_pkg::TYPE_RLE_BIT]) begin
      hdr_err = tga_pkg::ERR_COMPRESSED;
    end else if ((tlow != tga_pkg::TYPE_MAPPED) && (tlow != tga_pkg::TYPE_TRUE) &&
                 (tlow != tga_pkg::TYPE_GRAY)) begin
      hdr_err = tga_pkg::ERR_BAD_TYPE;
    end else if (!fmt_ok) begin
      hdr_err = tga_pkg::ERR_BAD_FORMAT;
    end else if ({1'b0, palette_count} > PAL_LIM) begin
      hdr_err = tga_pkg::ERR_PAL_LARGE;
    end
  end

  assign id_dec   = id_left - 8'd1;
  assign pos_inc  = palette_pos + PW'(1);
  assign is_true  = (tlow == tga_pkg::TYPE_TRUE);
  assign is_32    = (depth_bits == tga_pkg::DEPTH_32);
  // Last stored byte of the pixel arrives with this byte
  assign pix_done = !is_true || (is_32 ? (byte_in_pixel == 2'd3) : (byte_in_pixel == 2'd2));
  assign col_inc  = col_count + DIM_BITS'(1);
  assign rows_inc = rows_done + DIM_BITS'(1);

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    id_left_next       = id_left;
    palette_kind_next  = palette_kind;
    type_code_next     = type_code;
    palette_count_next = palette_count;
    palette_pos_next   = palette_pos;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    depth_bits_next    = depth_bits;
    top_origin_next    = top_origin;
    byte_in_pixel_next = byte_in_pixel;
    pixel_bytes_next   = pixel_bytes;
    col_count_next     = col_count;
    rows_done_next     = rows_done;
    res_new            = '0;
    res_fire           = 1'b0;

    if (take) begin
      if (fs) begin
        // Restart: clear the counters that the later phases rely on
        phase_next         = tga_pkg::PH_HEADER;
        palette_pos_next   = '0;
        byte_in_pixel_next = 2'd0;
        pixel_bytes_next   = '0;
        col_count_next     = '0;
        rows_done_next     = '0;
      end
      case (ph)
        tga_pkg::PH_HEADER: begin
          case (hc)
            tga_pkg::HDR_ID_LEN:     id_left_next = b;
            tga_pkg::HDR_CMAP_TYPE:  palette_kind_next = b;
            tga_pkg::HDR_IMG_TYPE:   type_code_next = b;
            tga_pkg::HDR_CMAP_LEN_L: palette_count_next = {8'd0, b};
            tga_pkg::HDR_CMAP_LEN_H: palette_count_next = {b, palette_count[7:0]};
            tga_pkg::HDR_WIDTH_L:    width_reg_next = {8'd0, b};
            tga_pkg::HDR_WIDTH_H:    width_reg_next = {b, width_reg[7:0]};
            tga_pkg::HDR_HEIGHT_L:   height_reg_next = {8'd0, b};
            tga_pkg::HDR_HEIGHT_H:   height_reg_next = {b, height_reg[7:0]};
            tga_pkg::HDR_DEPTH:      depth_bits_next = b;
            tga_pkg::HDR_DESC:       top_origin_next = b[tga_pkg::DESC_TOP_BIT];
            default: ;
          endcase
          if (hc != tga_pkg::HDR_DESC) begin
            header_count_next = hc + 5'd1;
          end else begin
            res_fire = 1'b1;
            if (hdr_err != tga_pkg::ERR_NONE) begin
              phase_next         = tga_pkg::PH_IDLE;
              res_new.kind       = tga_pkg::KIND_ERROR;
              res_new.error_code = hdr_err;
            end else begin
              phase_next        = (id_left != 8'd0) ? tga_pkg::PH_ID : after_id;
              res_new.kind      = tga_pkg::KIND_INFO;
              res_new.col       = width_reg;
              res_new.row       = height_reg;
              res_new.comp0     = hdr_fmt;
              res_new.image_end = empty_img;
            end
          end
        end
        tga_pkg::PH_ID: begin
          // Drop the image ID bytes
          id_left_next = id_dec;
          if (id_dec == 8'd0) begin
            phase_next = after_id;
          end
        end
        tga_pkg::PH_PALETTE: begin
          if (byte_in_pixel != 2'd2) begin
            pixel_bytes_next[byte_in_pixel] = b;
            byte_in_pixel_next = byte_in_pixel + 2'd1;
          end else begin
            res_fire       = 1'b1;
            res_new.kind   = tga_pkg::KIND_PALETTE;
            res_new.col    = 16'(palette_pos);
            res_new.comp0  = pixel_bytes[0];
            res_new.comp1  = pixel_bytes[1];
            res_new.comp2  = b;
            byte_in_pixel_next = 2'd0;
            pixel_bytes_next   = '0;
            palette_pos_next   = pos_inc;
            if (17'(pos_inc) >= {1'b0, palette_count}) begin
              phase_next = empty_img ? tga_pkg::PH_IDLE : tga_pkg::PH_PIXELS;
            end
          end
        end
        tga_pkg::PH_PIXELS: begin
          if (!pix_done) begin
            case (byte_in_pixel)
              2'd0:    pixel_bytes_next[0] = b;
              2'd1:    pixel_bytes_next[1] = b;
              2'd2:    pixel_bytes_next[2] = b;
              default: ;
            endcase
            byte_in_pixel_next = byte_in_pixel + 2'd1;
          end else begin
            res_fire     = 1'b1;
            res_new.kind = tga_pkg::KIND_PIXEL;
            res_new.col  = 16'(col_count);
            res_new.row  = top_origin ? 16'(rows_done) :
                                        (height_reg - 16'd1 - 16'(rows_done));
            if (!is_true) begin
              res_new.comp0 = b;
            end else if (!is_32) begin
              // Stored B,G,R: swap first and third
              res_new.comp0 = b;
              res_new.comp1 = pixel_bytes[1];
              res_new.comp2 = pixel_bytes[0];
            end else begin
              res_new.comp0 = pixel_bytes[2];
              res_new.comp1 = pixel_bytes[1];
              res_new.comp2 = pixel_bytes[0];
              res_new.comp3 = b;
            end
            res_new.image_end = (16'(col_inc) == width_reg) && (16'(rows_inc) == height_reg);
            byte_in_pixel_next = 2'd0;
            pixel_bytes_next   = '0;
            col_count_next     = col_inc;
            if (16'(col_inc) >= width_reg) begin
              // Advance to the next row
              col_count_next = '0;
              rows_done_next = rows_inc;
              if (16'(rows_inc) >= height_reg) begin
                phase_next = tga_pkg::PH_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register: load on a new result, drop once the transfer completes
  always_comb begin
    res_valid_next = res_valid;
    if (take && res_fire) begin
      res_valid_next = 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tga_pkg::PH_HEADER;
      header_count  <= 5'd0;
      id_left       <= 8'd0;
      palette_kind  <= 8'd0;
      type_code     <= 8'd0;
      palette_count <= 16'd0;
      palette_pos   <= '0;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      depth_bits    <= 8'd0;
      top_origin    <= 1'b0;
      byte_in_pixel <= 2'd0;
      pixel_bytes   <= '0;
      col_count     <= '0;
      rows_done     <= '0;
      res_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      id_left       <= id_left_next;
      palette_kind  <= palette_kind_next;
      type_code     <= type_code_next;
      palette_count <= palette_count_next;
      palette_pos   <= palette_pos_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      depth_bits    <= depth_bits_next;
      top_origin    <= top_origin_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_bytes   <= pixel_bytes_next;
      col_count     <= col_count_next;
      rows_done     <= rows_done_next;
      res_valid     <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_fire) begin
      res_data <= res_new;
    end
  end

  // Error results carry a code and nothing else
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind == tga_pkg::KIND_ERROR) |->
      (res_data.error_code != tga_pkg::ERR_NONE) && (res_data.col == 16'd0) &&
      (res_data.row == 16'd0) && !res_data.image_end)
    else $error("error result malformed");

  // Only error results carry a code
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind != tga_pkg::KIND_ERROR) |->
      (res_data.error_code == tga_pkg::ERR_NONE))
    else $error("error code on non-error result");

  // A pixel column stays inside the image width
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind == tga_pkg::KIND_PIXEL) |-> (res_data.col < width_reg))
    else $error("pixel column beyond width");

  // Palette entries are three bytes, so the byte counter never passes two
  assert property (@(posedge clk) disable iff (rst)
    (phase == tga_pkg::PH_PALETTE) |-> (byte_in_pixel != 2'd3))
    else $error("palette byte counter overrun");

  // The header counter stops at the descriptor byte
  assert property (@(posedge clk) disable iff (rst)
    header_count <= tga_pkg::HDR_DESC)
    else $error("header counter overrun");

endmodule
